// ----- rtl/ebv_pkg.sv -----
// ebv_pkg: shared types, sine polynomial coefficients and the q30 product helper
// used by the sine units and the basis stage; depends on nothing
package ebv_pkg;

    // sine/cosine of pitch, yaw and roll, signed q30
    typedef struct packed {
        logic signed [31:0] sp;
        logic signed [31:0] cp;
        logic signed [31:0] sy;
        logic signed [31:0] cy;
        logic signed [31:0] sr;
        logic signed [31:0] cr;
    } trig_t;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] POLY_C1 = 31'd1686629713;
    localparam logic [30:0] POLY_C3 = 31'd693598668;
    localparam logic [30:0] POLY_C5 = 31'd85569306;
    localparam logic [30:0] POLY_C7 = 31'd5026995;
    localparam logic [30:0] POLY_C9 = 31'd172272;

    // q30 by q30, rounded half away from zero; operands stay within +/-1.0
    function automatic logic signed [31:0] mul_q30(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic        neg;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [61:0] p;
        logic [31:0] q;
        neg = a[31] ^ b[31];
        ua  = a[31] ? 32'(-a) : 32'(a);
        ub  = b[31] ? 32'(-b) : 32'(b);
        p   = 62'(ua[30:0]) * 62'(ub[30:0]);
        p   = p + (62'd1 << 29);
        q   = {1'b0, p[60:30]};
        return neg ? $signed(-q) : $signed(q);
    endfunction

endpackage

// ----- rtl/ebv_sine.sv -----
// ebv_sine: seven-stage pipelined quarter-wave polynomial sine in q30
// depends on ebv_pkg
module ebv_sine #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                    clk,
    input  logic [ANGLE_BITS-1:0]   angle,
    output logic signed [31:0]      sine
);
    localparam int PAD = 32 - ANGLE_BITS;

    logic [30:0] x_next;
    logic [30:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg, x6_reg;
    logic        n1_reg, n2_reg, n3_reg, n4_reg, n5_reg, n6_reg;
    logic [30:0] xx_reg, xx3_reg, xx4_reg, xx5_reg;
    logic [30:0] t7_reg, t5_reg, t3_reg, t1_reg;
    logic signed [31:0] sine_reg;
    logic [61:0] sq, pr7, pr5, pr3, pr1, prf;
    logic [31:0] mag;

    always_comb
    begin
        x_next = {1'b0, angle[ANGLE_BITS-3:0], {PAD{1'b0}}};
        if (angle[ANGLE_BITS-2])
        begin
            x_next = ebv_pkg::Q30_ONE - x_next;
        end
        sq  = 62'(x1_reg) * 62'(x1_reg);
        pr7 = 62'(xx_reg) * 62'(ebv_pkg::POLY_C9);
        pr5 = 62'(xx3_reg) * 62'(t7_reg);
        pr3 = 62'(xx4_reg) * 62'(t5_reg);
        pr1 = 62'(xx5_reg) * 62'(t3_reg);
        prf = 62'(x6_reg) * 62'(t1_reg);
        mag = prf[61:30];
        if (mag > 32'(ebv_pkg::Q30_ONE))
        begin
            mag = 32'(ebv_pkg::Q30_ONE);
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= x_next;
        n1_reg   <= angle[ANGLE_BITS-1];
        x2_reg   <= x1_reg;  n2_reg <= n1_reg;
        x3_reg   <= x2_reg;  n3_reg <= n2_reg;
        x4_reg   <= x3_reg;  n4_reg <= n3_reg;
        x5_reg   <= x4_reg;  n5_reg <= n4_reg;
        x6_reg   <= x5_reg;  n6_reg <= n5_reg;
        xx_reg   <= sq[60:30];
        xx3_reg  <= xx_reg;
        xx4_reg  <= xx3_reg;
        xx5_reg  <= xx4_reg;
        t7_reg   <= ebv_pkg::POLY_C7 - pr7[60:30];
        t5_reg   <= ebv_pkg::POLY_C5 - pr5[60:30];
        t3_reg   <= ebv_pkg::POLY_C3 - pr3[60:30];
        t1_reg   <= ebv_pkg::POLY_C1 - pr1[60:30];
        sine_reg <= n6_reg ? $signed(-mag) : $signed(mag);
    end

    // x squared travels down its own delay line so each horner step sees its own item
    assign sine = sine_reg;
endmodule

// ----- rtl/ebv_basis.sv -----
// ebv_basis: three-stage product, triple product and output scaling pipeline
// depends on ebv_pkg
module ebv_basis #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                            clk,
    input  ebv_pkg::trig_t                  trig,
    output logic signed [FRACTION_BITS+1:0] forward_x,
    output logic signed [FRACTION_BITS+1:0] forward_y,
    output logic signed [FRACTION_BITS+1:0] forward_z,
    output logic signed [FRACTION_BITS+1:0] right_x,
    output logic signed [FRACTION_BITS+1:0] right_y,
    output logic signed [FRACTION_BITS+1:0] right_z,
    output logic signed [FRACTION_BITS+1:0] up_x,
    output logic signed [FRACTION_BITS+1:0] up_y,
    output logic signed [FRACTION_BITS+1:0] up_z
);
    localparam int OW = FRACTION_BITS + 2;
    localparam int SH = 30 - FRACTION_BITS;
    localparam logic [32:0] HALF = (33'd1 << SH) >> 1;
    localparam logic [32:0] LIM  = 33'd1 << FRACTION_BITS;

    function automatic logic [OW-1:0] to_out(logic signed [32:0] v);
        logic [32:0] m;
        logic [32:0] r;
        m = v[32] ? 33'(-v) : 33'(v);
        r = (m + HALF) >> SH;
        if (r > LIM)
        begin
            r = LIM;
        end
        return v[32] ? OW'(-r) : OW'(r);
    endfunction

    logic signed [31:0] srsp_reg, crsp_reg, cpcy_reg, cpsy_reg, srcp_reg, crcp_reg;
    logic signed [31:0] crsy_reg, crcy_reg, srsy_reg, srcy_reg, sp_reg;
    logic signed [31:0] b_cpcy_reg, b_cpsy_reg, b_srcp_reg, b_crcp_reg;
    logic signed [31:0] b_crsy_reg, b_crcy_reg, b_srsy_reg, b_srcy_reg, b_sp_reg;
    logic signed [31:0] cy_reg, sy_reg;
    logic signed [31:0] ssc_reg, sss_reg, csc_reg, css_reg;
    logic [OW-1:0] o_reg [9];

    always_ff @(posedge clk)
    begin
        // products of pairs
        srsp_reg <= ebv_pkg::mul_q30(trig.sr, trig.sp);
        crsp_reg <= ebv_pkg::mul_q30(trig.cr, trig.sp);
        cpcy_reg <= ebv_pkg::mul_q30(trig.cp, trig.cy);
        cpsy_reg <= ebv_pkg::mul_q30(trig.cp, trig.sy);
        srcp_reg <= ebv_pkg::mul_q30(trig.sr, trig.cp);
        crcp_reg <= ebv_pkg::mul_q30(trig.cr, trig.cp);
        crsy_reg <= ebv_pkg::mul_q30(trig.cr, trig.sy);
        crcy_reg <= ebv_pkg::mul_q30(trig.cr, trig.cy);
        srsy_reg <= ebv_pkg::mul_q30(trig.sr, trig.sy);
        srcy_reg <= ebv_pkg::mul_q30(trig.sr, trig.cy);
        sp_reg   <= trig.sp;
        cy_reg   <= trig.cy;
        sy_reg   <= trig.sy;
        // triple products
        ssc_reg    <= ebv_pkg::mul_q30(srsp_reg, cy_reg);
        sss_reg    <= ebv_pkg::mul_q30(srsp_reg, sy_reg);
        csc_reg    <= ebv_pkg::mul_q30(crsp_reg, cy_reg);
        css_reg    <= ebv_pkg::mul_q30(crsp_reg, sy_reg);
        b_cpcy_reg <= cpcy_reg;
        b_cpsy_reg <= cpsy_reg;
        b_srcp_reg <= srcp_reg;
        b_crcp_reg <= crcp_reg;
        b_crsy_reg <= crsy_reg;
        b_crcy_reg <= crcy_reg;
        b_srsy_reg <= srsy_reg;
        b_srcy_reg <= srcy_reg;
        b_sp_reg   <= sp_reg;
        // sums and scaling
        o_reg[0] <= to_out(33'(b_cpcy_reg));
        o_reg[1] <= to_out(33'(b_cpsy_reg));
        o_reg[2] <= to_out(-33'(b_sp_reg));
        o_reg[3] <= to_out(33'(b_crsy_reg) - 33'(ssc_reg));
        o_reg[4] <= to_out(-33'(sss_reg) - 33'(b_crcy_reg));
        o_reg[5] <= to_out(-33'(b_srcp_reg));
        o_reg[6] <= to_out(33'(csc_reg) + 33'(b_srsy_reg));
        o_reg[7] <= to_out(33'(css_reg) - 33'(b_srcy_reg));
        o_reg[8] <= to_out(33'(b_crcp_reg));
    end

    assign forward_x = o_reg[0];
    assign forward_y = o_reg[1];
    assign forward_z = o_reg[2];
    assign right_x   = o_reg[3];
    assign right_y   = o_reg[4];
    assign right_z   = o_reg[5];
    assign up_x      = o_reg[6];
    assign up_y      = o_reg[7];
    assign up_z      = o_reg[8];
endmodule

// ----- rtl/euler_angles_to_basis_vectors.sv -----
// an accepted request's done strobe leaves the end of the valid shift register together with its result
// throughput: one request per cycle; busy is tied low, the pipeline never stalls
// seven stages are the sine: quadrant fold, then one multiply per stage; three the basis
// reset clears only the valid bits; data registers run free
// the receiver cannot stall: each result shows on the ports for one cycle only
// depends on ebv_pkg, ebv_sine, ebv_basis
module euler_angles_to_basis_vectors #(
    parameter int ANGLE_BITS    = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ANGLE_BITS-1:0]           pitch_angle,
    input  logic [ANGLE_BITS-1:0]           yaw_angle,
    input  logic [ANGLE_BITS-1:0]           roll_angle,
    output logic                            done,
    output logic signed [FRACTION_BITS+1:0] forward_x,
    output logic signed [FRACTION_BITS+1:0] forward_y,
    output logic signed [FRACTION_BITS+1:0] forward_z,
    output logic signed [FRACTION_BITS+1:0] right_x,
    output logic signed [FRACTION_BITS+1:0] right_y,
    output logic signed [FRACTION_BITS+1:0] right_z,
    output logic signed [FRACTION_BITS+1:0] up_x,
    output logic signed [FRACTION_BITS+1:0] up_y,
    output logic signed [FRACTION_BITS+1:0] up_z
);
    localparam int LATENCY = 10;
    // cosine is the sine a quarter turn ahead
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic [LATENCY-1:0] valid_reg;
    logic [LATENCY-1:0] valid_next;
    ebv_pkg::trig_t     trig;

    // valid bits travel alongside the free-running data pipeline
    assign valid_next = {valid_reg[LATENCY-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign busy = 1'b0;
    assign done = valid_reg[LATENCY-1];

    // six sine pipelines: sine and cosine of each angle
    ebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sp (.clk(clk), .angle(pitch_angle),
                                              .sine(trig.sp));
    ebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cp (.clk(clk), .angle(pitch_angle + QUARTER),
                                              .sine(trig.cp));
    ebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sy (.clk(clk), .angle(yaw_angle),
                                              .sine(trig.sy));
    ebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cy (.clk(clk), .angle(yaw_angle + QUARTER),
                                              .sine(trig.cy));
    ebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sr (.clk(clk), .angle(roll_angle),
                                              .sine(trig.sr));
    ebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cr (.clk(clk), .angle(roll_angle + QUARTER),
                                              .sine(trig.cr));

    // products, triple products, then sums with rounding and saturation
    ebv_basis #(.FRACTION_BITS(FRACTION_BITS)) u_basis (
        .clk       (clk),
        .trig      (trig),
        .forward_x (forward_x),
        .forward_y (forward_y),
        .forward_z (forward_z),
        .right_x   (right_x),
        .right_y   (right_y),
        .right_z   (right_z),
        .up_x      (up_x),
        .up_y      (up_y),
        .up_z      (up_z)
    );
endmodule

// ----- rtl/ebv_checker.sv -----
// ebv_checker: port-level checks on request timing and result range
// bound to euler_angles_to_basis_vectors; depends on nothing
module ebv_checker #(
    parameter int FRACTION_BITS = 14
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic signed [FRACTION_BITS+1:0] forward_z,
    input logic signed [FRACTION_BITS+1:0] up_z
);
    localparam logic signed [FRACTION_BITS+1:0] ONE = (FRACTION_BITS+2)'(1) << FRACTION_BITS;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##10 done)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##10 !done)
        else $error("result without request");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (up_z <= ONE && up_z >= -ONE && forward_z <= ONE && forward_z >= -ONE))
        else $error("component beyond unit range");
endmodule

bind euler_angles_to_basis_vectors ebv_checker #(.FRACTION_BITS(FRACTION_BITS)) u_ebv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .forward_z (forward_z),
    .up_z      (up_z)
);

// ----- tb/tb_euler_angles_to_basis_vectors.sv -----
// testbench for euler_angles_to_basis_vectors: random and directed angle requests,
// results checked against an in-bench q30 predictor; depends on the rtl only
module tb_euler_angles_to_basis_vectors;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AB = 16;
    localparam int FB = 14;
    localparam int LATENCY = 10;

    typedef struct {
        logic [AB-1:0] pitch;
        logic [AB-1:0] yaw;
        logic [AB-1:0] roll;
    } angles_t;

    typedef struct {
        logic signed [FB+1:0] v [9];
    } basis_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [AB-1:0] pitch_angle;
    logic [AB-1:0] yaw_angle;
    logic [AB-1:0] roll_angle;
    logic done;
    logic signed [FB+1:0] forward_x, forward_y, forward_z;
    logic signed [FB+1:0] right_x, right_y, right_z;
    logic signed [FB+1:0] up_x, up_y, up_z;

    euler_angles_to_basis_vectors dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
        .done(done),
        .forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
        .right_x(right_x), .right_y(right_y), .right_z(right_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z)
    );

    angles_t pending_requests [$];
    basis_t  expected_basis [$];
    int      mismatches;
    int      accepted_count;
    bit      quiet_stretch;

    // busy as seen at the accepting rising edge
    angles_t held_request;
    logic    busy_sampled;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // odd polynomial for sin over a quarter turn, truncating q30 horner steps
    function automatic longint quarter_sine(longint x);
        longint x2;
        longint t;
        x2 = (x * x) >>> 30;
        t = 172272;
        t = 5026995 - ((x2 * t) >>> 30);
        t = 85569306 - ((x2 * t) >>> 30);
        t = 693598668 - ((x2 * t) >>> 30);
        t = 1686629713 - ((x2 * t) >>> 30);
        t = (x * t) >>> 30;
        if (t > (longint'(1) << 30))
            t = longint'(1) << 30;
        return t;
    endfunction

    // binary angle to q30 sine, quadrant folded from the top two bits
    function automatic longint angle_sine(logic [AB-1:0] a);
        logic [1:0] quad;
        longint x;
        longint m;
        quad = a[AB-1:AB-2];
        x = longint'(a[AB-3:0]) << (32 - AB);
        if (quad[0])
            x = (longint'(1) << 30) - x;
        m = quarter_sine(x);
        return quad[1] ? -m : m;
    endfunction

    // q30 product, magnitude rounded half away from zero
    function automatic longint q30_product(longint a, longint b);
        longint ma;
        longint mb;
        longint p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb + (longint'(1) << 29)) >>> 30;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    // q30 down to q1.14, rounded half away from zero, saturated to +/-1.0
    function automatic logic signed [FB+1:0] q30_to_out(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (29 - FB))) >>> (30 - FB);
        if (m > (longint'(1) << FB))
            m = longint'(1) << FB;
        return (v < 0) ? (FB+2)'(-m) : (FB+2)'(m);
    endfunction

    function automatic basis_t predict_basis(angles_t a);
        basis_t b;
        logic [AB-1:0] qt;
        longint sp, cp, sy, cy, sr, cr, srsp, crsp;
        qt = AB'(1) << (AB - 2);
        sp = angle_sine(a.pitch);
        cp = angle_sine(a.pitch + qt);
        sy = angle_sine(a.yaw);
        cy = angle_sine(a.yaw + qt);
        sr = angle_sine(a.roll);
        cr = angle_sine(a.roll + qt);
        srsp = q30_product(sr, sp);
        crsp = q30_product(cr, sp);
        b.v[0] = q30_to_out(q30_product(cp, cy));
        b.v[1] = q30_to_out(q30_product(cp, sy));
        b.v[2] = q30_to_out(-sp);
        b.v[3] = q30_to_out(-q30_product(srsp, cy) + q30_product(cr, sy));
        b.v[4] = q30_to_out(-q30_product(srsp, sy) - q30_product(cr, cy));
        b.v[5] = q30_to_out(-q30_product(sr, cp));
        b.v[6] = q30_to_out(q30_product(crsp, cy) + q30_product(sr, sy));
        b.v[7] = q30_to_out(q30_product(crsp, sy) - q30_product(sr, cy));
        b.v[8] = q30_to_out(q30_product(cr, cp));
        return b;
    endfunction

    // driver: inputs move on the falling edge; a request is taken at the next
    // rising edge if start is high and busy is low
    always @(negedge clk)
    begin
        angles_t req;
        if (rst_n)
        begin
            // the last request was accepted at the rising edge just gone
            if (start && !busy_sampled)
            begin
                expected_basis.push_back(predict_basis(held_request));
                void'(pending_requests.pop_front());
                accepted_count++;
            end
            // a long stretch with no idling in the middle of the run
            quiet_stretch = (accepted_count >= 300 && accepted_count < 450);
            if (pending_requests.size() > 0 &&
                (quiet_stretch || $urandom_range(99) >= 14))
            begin
                req = pending_requests[0];
                held_request <= req;
                pitch_angle <= req.pitch;
                yaw_angle <= req.yaw;
                roll_angle <= req.roll;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
                pitch_angle <= AB'($urandom);
                yaw_angle <= AB'($urandom);
                roll_angle <= AB'($urandom);
            end
        end
    end

    always @(posedge clk)
        busy_sampled <= busy;

    // monitor: every done strobe is compared with the oldest prediction
    always @(posedge clk)
    begin
        basis_t exp_b;
        logic signed [FB+1:0] got [9];
        if (rst_n && done)
        begin
            got = '{forward_x, forward_y, forward_z, right_x, right_y, right_z,
                    up_x, up_y, up_z};
            if (expected_basis.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result strobe at %0t", $time);
            end
            else
            begin
                exp_b = expected_basis.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== exp_b.v[i])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("component %0d: expected %0d actual %0d",
                                     i, exp_b.v[i], got[i]);
                    end
            end
        end
    end

    task automatic queue_request(logic [AB-1:0] p, logic [AB-1:0] y, logic [AB-1:0] r);
        angles_t a;
        a.pitch = p;
        a.yaw = y;
        a.roll = r;
        pending_requests.push_back(a);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        pitch_angle = '0;
        yaw_angle = '0;
        roll_angle = '0;
        busy_sampled = 1'b0;
        mismatches = 0;
        accepted_count = 0;
        // directed: zero, every quadrant boundary, one below, all ones, saturating poles
        queue_request(16'h0000, 16'h0000, 16'h0000);
        queue_request(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_request(16'h4000, 16'h0000, 16'h0000);
        queue_request(16'hC000, 16'h4000, 16'h8000);
        queue_request(16'h8000, 16'hC000, 16'h4000);
        queue_request(16'h3FFF, 16'h7FFF, 16'hBFFF);
        queue_request(16'h4001, 16'h8001, 16'hC001);
        queue_request(16'h0001, 16'h0001, 16'h0001);
        queue_request(16'h2000, 16'h6000, 16'hA000);
        queue_request(16'hE000, 16'h2000, 16'h6000);
        queue_request(16'h5555, 16'hAAAA, 16'h5555);
        queue_request(16'hAAAA, 16'h5555, 16'hAAAA);
        queue_request(16'h4000, 16'h4000, 16'h4000);
        queue_request(16'hC000, 16'hC000, 16'hC000);
        for (int i = 0; i < 800; i++)
        begin
            if ($urandom_range(9) == 0)
                queue_request(AB'($urandom_range(3) << 14), AB'($urandom_range(3) << 14),
                              AB'($urandom));
            else
                queue_request(AB'($urandom), AB'($urandom), AB'($urandom));
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_requests.size() == 0);
        @(negedge clk);
        @(negedge clk);
        wait (expected_basis.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatches == 0 && expected_basis.size() == 0)
            $display("tb_euler_angles_to_basis_vectors OK");
        else
            $display("tb_euler_angles_to_basis_vectors NOT OK");
        $finish;
    end

    initial
    begin
        #200000;
        $display("tb_euler_angles_to_basis_vectors NOT OK");
        $finish;
    end

endmodule
